// ----- sv/bdfc_pkg.sv -----
// shared types and constants of the bit destuffing frame checker
`default_nettype none
package bdfc_pkg;

  localparam int unsigned KEPT_W    = 17;
  localparam int unsigned TOTAL_W   = 13;
  localparam int unsigned RUN_W     = 3;
  localparam int unsigned MAXBITS_W = 16;

  localparam logic [KEPT_W-1:0]    KEPT_MAX       = 17'h1FFFF;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX      = 13'h1FFF;
  localparam logic [MAXBITS_W-1:0] MAX_BITS_RESET = 16'd8000;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_VIOLATION = 2'd1,
    ST_NOT_BYTE  = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  // work handed from the front to the back: an optional byte, an optional status
  typedef struct packed {
    logic                has_byte;
    logic [7:0]          data_byte;
    logic                has_status;
    status_t             status_code;
    logic [TOTAL_W-1:0]  byte_total;
  } entry_t;

  // queue state seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage
`default_nettype wire

// ----- sv/bdfc_in_if.sv -----
// input bit channel
`default_nettype none
interface bdfc_in_if;
  logic valid;
  logic ready;
  logic bit_in;
  logic frame_end;

  modport source (output valid, output bit_in, output frame_end, input ready);
  modport sink   (input valid, input bit_in, input frame_end, output ready);
endinterface
`default_nettype wire

// ----- sv/bdfc_out_if.sv -----
// result channel
`default_nettype none
interface bdfc_out_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [7:0]  data_byte;
  logic [1:0]  status_code;
  logic [12:0] byte_total;
  logic        last_result;

  modport source (output valid, output is_status, output data_byte, output status_code,
                  output byte_total, output last_result, input ready);
  modport sink   (input valid, input is_status, input data_byte, input status_code,
                  input byte_total, input last_result, output ready);
endinterface
`default_nettype wire

// ----- sv/bdfc_cfg_if.sv -----
// configuration write channel carrying max_bits
`default_nettype none
interface bdfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_bits;

  modport source (output valid, output max_bits, input ready);
  modport sink   (input valid, input max_bits, output ready);
endinterface
`default_nettype wire

// ----- sv/bdfc_front.sv -----
// front end: destuffs each bit, packs bytes and classifies the frame status
`default_nettype none
module bdfc_front #(
  parameter int unsigned RUN_LIMIT = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  bdfc_in_if.sink              in_chan,
  bdfc_cfg_if.sink             cfg_chan,
  input  wire bdfc_pkg::qstat_t qstat,
  output logic                 push,
  output bdfc_pkg::entry_t     push_entry
);

  localparam logic [bdfc_pkg::RUN_W-1:0] RUN_LIM = bdfc_pkg::RUN_W'(RUN_LIMIT);

  logic [bdfc_pkg::MAXBITS_W-1:0] max_bits_r, max_bits_nxt;
  logic [bdfc_pkg::RUN_W-1:0]     ones_r, ones_nxt, ones_upd;
  logic [bdfc_pkg::KEPT_W-1:0]    kept_r, kept_nxt, kept_upd;
  logic [7:0]                     shift_r, shift_nxt, shift_upd;
  logic                           viol_r, viol_nxt, viol_upd;
  logic                           accept;
  logic                           emit_byte;
  bdfc_pkg::status_t              code;
  logic [bdfc_pkg::TOTAL_W-1:0]   total;

  assign in_chan.ready  = !qstat.full;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;

  always_comb begin
    ones_upd  = ones_r;
    kept_upd  = kept_r;
    shift_upd = shift_r;
    viol_upd  = viol_r;
    emit_byte = 1'b0;
    if (!viol_r) begin
      if (ones_r == RUN_LIM) begin
        if (in_chan.bit_in) begin
          viol_upd = 1'b1;
        end else begin
          ones_upd = '0;
        end
      end else begin
        ones_upd  = in_chan.bit_in ? ones_r + 1'b1 : '0;
        shift_upd = {shift_r[6:0], in_chan.bit_in};
        if (kept_r != bdfc_pkg::KEPT_MAX) begin
          kept_upd  = kept_r + 1'b1;
          emit_byte = (kept_upd[2:0] == 3'd0);
        end
      end
    end
  end

  // status from the updated state
  always_comb begin
    if (viol_upd) begin
      code = bdfc_pkg::ST_VIOLATION;
    end else if (kept_upd[2:0] != 3'd0) begin
      code = bdfc_pkg::ST_NOT_BYTE;
    end else if (kept_upd > {1'b0, max_bits_r}) begin
      code = bdfc_pkg::ST_TOO_LONG;
    end else begin
      code = bdfc_pkg::ST_OK;
    end
    total = kept_upd[bdfc_pkg::KEPT_W-1] ? bdfc_pkg::TOTAL_MAX
                                          : kept_upd[bdfc_pkg::KEPT_W-2:3];
  end

  always_comb begin
    push                   = accept && (emit_byte || in_chan.frame_end);
    push_entry.has_byte    = emit_byte;
    push_entry.data_byte   = shift_upd;
    push_entry.has_status  = in_chan.frame_end;
    push_entry.status_code = code;
    push_entry.byte_total  = total;
  end

  always_comb begin
    max_bits_nxt = cfg_chan.valid ? cfg_chan.max_bits : max_bits_r;
    ones_nxt     = ones_r;
    kept_nxt     = kept_r;
    shift_nxt    = shift_r;
    viol_nxt     = viol_r;
    if (accept) begin
      if (in_chan.frame_end) begin
        ones_nxt  = '0;
        kept_nxt  = '0;
        shift_nxt = '0;
        viol_nxt  = 1'b0;
      end else begin
        ones_nxt  = ones_upd;
        kept_nxt  = kept_upd;
        shift_nxt = shift_upd;
        viol_nxt  = viol_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bits_r <= bdfc_pkg::MAX_BITS_RESET;
      ones_r     <= '0;
      kept_r     <= '0;
      shift_r    <= '0;
      viol_r     <= 1'b0;
    end else begin
      max_bits_r <= max_bits_nxt;
      ones_r     <= ones_nxt;
      kept_r     <= kept_nxt;
      shift_r    <= shift_nxt;
      viol_r     <= viol_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bdfc_queue.sv -----
// short work queue between front and back
`default_nettype none
module bdfc_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bdfc_pkg::entry_t push_entry,
  input  wire logic             pop,
  output bdfc_pkg::entry_t      head,
  output bdfc_pkg::qstat_t      qstat
);

  bdfc_pkg::entry_t               store_r [bdfc_pkg::QUEUE_DEPTH];
  logic [bdfc_pkg::QPTR_W-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [bdfc_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign head        = store_r[rd_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == bdfc_pkg::QCNT_W'(bdfc_pkg::QUEUE_DEPTH));

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + bdfc_pkg::QCNT_W'(push) - bdfc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty))
    else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= bdfc_pkg::QCNT_W'(bdfc_pkg::QUEUE_DEPTH)) &&
    ((wr_r - rd_r) == cnt_r[bdfc_pkg::QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

  a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !qstat.empty)
    else $error("queue empty after push");

endmodule
`default_nettype wire

// ----- sv/bdfc_back.sv -----
// back end: turns queued work into result requests through an output register
`default_nettype none
module bdfc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bdfc_pkg::entry_t head,
  input  wire bdfc_pkg::qstat_t qstat,
  output logic                  pop,
  bdfc_out_if.source            out_chan
);

  logic        valid_r, valid_nxt;
  logic        sent_r, sent_nxt;
  logic        is_status_r, is_status_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [1:0]  code_r, code_nxt;
  logic [12:0] total_r, total_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic        byte_turn;

  assign load      = !valid_r || out_chan.ready;
  assign byte_turn = head.has_byte && !sent_r;

  always_comb begin
    valid_nxt     = valid_r;
    sent_nxt      = sent_r;
    is_status_nxt = is_status_r;
    data_nxt      = data_r;
    code_nxt      = code_r;
    total_nxt     = total_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = !qstat.empty;
      if (!qstat.empty) begin
        if (byte_turn) begin
          is_status_nxt = 1'b0;
          data_nxt      = head.data_byte;
          code_nxt      = bdfc_pkg::ST_OK;
          total_nxt     = '0;
          last_nxt      = !head.has_status;
          sent_nxt      = head.has_status;
          pop           = !head.has_status;
        end else begin
          is_status_nxt = 1'b1;
          data_nxt      = '0;
          code_nxt      = head.status_code;
          total_nxt     = head.byte_total;
          last_nxt      = 1'b1;
          sent_nxt      = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sent_r  <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_status_r <= is_status_nxt;
    data_r      <= data_nxt;
    code_r      <= code_nxt;
    total_r     <= total_nxt;
    last_r      <= last_nxt;
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.is_status   = is_status_r;
  assign out_chan.data_byte   = data_r;
  assign out_chan.status_code = code_r;
  assign out_chan.byte_total  = total_r;
  assign out_chan.last_result = last_r;

  a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> (!qstat.empty && valid_r && !is_status_r && !last_r))
    else $error("split entry without pending byte");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && is_status_r) |-> last_r)
    else $error("status request not marked last");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !is_status_r) |-> (code_r == bdfc_pkg::ST_OK && total_r == '0))
    else $error("data request carries status fields");

endmodule
`default_nettype wire

// ----- sv/bit_destuff_frame_checker.sv -----
// top level of the bit destuffing frame checker
// usage:
//   in_chan takes one frame bit per request, with frame_end on the final bit.
//   out_chan gives data byte requests (is_status 0) as each destuffed byte
//   completes, and one status request (is_status 1, last_result 1) per frame.
//   cfg_chan writes max_bits and is always ready; the user must write it only
//   while idle, as the block does not enforce this.
// timing:
//   a bit's result is queued, then loaded into the output register. one input
//   bit is taken every cycle while the queue is not full; the output register
//   sends one result a cycle while out_chan.ready is high, so a final bit that
//   completes a byte needs two output results. a four-entry work queue between
//   the bit front end and the output register absorbs this.
// reset:
//   rst_n clears the frame state and the queue and sets max_bits to 8000.
// stall:
//   while out_chan.ready is low the result holds; the queue keeps taking bits
//   until it is full, and then in_chan.ready drops.
`default_nettype none
module bit_destuff_frame_checker #(
  parameter int unsigned RUN_LIMIT = 5
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bdfc_in_if.sink   in_chan,
  bdfc_out_if.source out_chan,
  bdfc_cfg_if.sink  cfg_chan
);

  bdfc_pkg::qstat_t qstat;
  bdfc_pkg::entry_t push_entry;
  bdfc_pkg::entry_t head;
  logic             push;
  logic             pop;

  bdfc_front #(
    .RUN_LIMIT(RUN_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  bdfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  bdfc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ----- test/bit_destuff_frame_checker_tb.sv -----
// testbench for the bit destuffing frame checker: directed rows, then predicted random frames
`timescale 1ns / 100ps

module bit_destuff_frame_checker_tb;

  localparam int unsigned STUFF_RUN      = 5;
  localparam int unsigned DRAIN_SLACK    = 8;
  localparam int unsigned END_WAIT_LIMIT = 100000;
  localparam int unsigned TIMEOUT_NS     = 1_000_000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct {
    logic              is_status;
    logic [7:0]        data_byte;
    bdfc_pkg::status_t status_code;
    logic [12:0]       byte_total;
    logic              last_result;
  } result_t;

  typedef enum logic {ROW_BIT, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_BYTE, EXP_STATUS, EXP_BOTH} exp_kind_e;

  typedef struct {
    row_kind_e         kind;
    bit                bit_val;
    bit                frame_end;
    logic [15:0]       cfg_val;
    exp_kind_e         exp_kind;
    logic [7:0]        data_byte;
    bdfc_pkg::status_t status_code;
    logic [12:0]       byte_total;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  bdfc_in_if  in_if ();
  bdfc_out_if out_if ();
  bdfc_cfg_if cfg_if ();

  bit_destuff_frame_checker #(
    .RUN_LIMIT(STUFF_RUN)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [2:0]  run_ones       = '0;
  logic [16:0] kept_count     = '0;
  logic [7:0]  shift_byte     = '0;
  logic        frame_violated = 1'b0;
  logic [15:0] max_bits_cfg   = bdfc_pkg::MAX_BITS_RESET;

  result_t fresh_results[$];
  result_t typed_results[$];
  result_t due_results[$];
  row_t    dir_rows[$];
  bit      frame_bits[$];

  int unsigned src_idle_pct = 38;
  int unsigned snk_idle_pct = 49;
  int unsigned fail_count;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned bits_sent;
  int unsigned useful_bits;
  int unsigned frames_sent;
  int unsigned cfg_writes;
  int unsigned status_mix[4];

  function automatic result_t byte_result(logic [7:0] byt, logic last);
    result_t r;
    r.is_status   = 1'b0;
    r.data_byte   = byt;
    r.status_code = bdfc_pkg::ST_OK;
    r.byte_total  = '0;
    r.last_result = last;
    return r;
  endfunction

  function automatic result_t status_result(bdfc_pkg::status_t code, logic [12:0] total);
    result_t r;
    r.is_status   = 1'b1;
    r.data_byte   = '0;
    r.status_code = code;
    r.byte_total  = total;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic void destuff_bit(bit b, bit fe);
    logic [13:0]       whole;
    logic [12:0]       total;
    bdfc_pkg::status_t code;
    fresh_results.delete();
    if (!frame_violated) begin
      if (run_ones == STUFF_RUN) begin
        if (b) frame_violated = 1'b1;
        else run_ones = '0;
      end else begin
        run_ones   = b ? run_ones + 3'd1 : 3'd0;
        shift_byte = {shift_byte[6:0], b};
        if (kept_count != bdfc_pkg::KEPT_MAX) begin
          kept_count = kept_count + 17'd1;
          if (kept_count[2:0] == 3'd0) fresh_results.push_back(byte_result(shift_byte, !fe));
        end
      end
    end
    if (fe) begin
      whole = kept_count[16:3];
      total = (whole > bdfc_pkg::TOTAL_MAX) ? bdfc_pkg::TOTAL_MAX : whole[12:0];
      if (frame_violated) code = bdfc_pkg::ST_VIOLATION;
      else if (kept_count[2:0] != 3'd0) code = bdfc_pkg::ST_NOT_BYTE;
      else if (kept_count > max_bits_cfg) code = bdfc_pkg::ST_TOO_LONG;
      else code = bdfc_pkg::ST_OK;
      fresh_results.push_back(status_result(code, total));
      run_ones       = '0;
      kept_count     = '0;
      shift_byte     = '0;
      frame_violated = 1'b0;
    end
  endfunction

  function automatic void add_row(row_kind_e k, bit b, bit fe, logic [15:0] cfg,
                                  exp_kind_e ek, logic [7:0] byt, bdfc_pkg::status_t code,
                                  logic [12:0] total);
    row_t r;
    r.kind        = k;
    r.bit_val     = b;
    r.frame_end   = fe;
    r.cfg_val     = cfg;
    r.exp_kind    = ek;
    r.data_byte   = byt;
    r.status_code = code;
    r.byte_total  = total;
    dir_rows.push_back(r);
  endfunction

  function automatic void note_mismatch(string what, bit have_want, result_t want, result_t got);
    fail_count++;
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      if (have_want)
        $display("%s: want st=%0b byte=%02h code=%0d total=%0d last=%0b", what,
                 want.is_status, want.data_byte, want.status_code, want.byte_total,
                 want.last_result);
      $display("%s: got  st=%0b byte=%02h code=%0d total=%0d last=%0b", what,
               got.is_status, got.data_byte, got.status_code, got.byte_total,
               got.last_result);
    end
  endfunction

  // sends one bit request; valid is left high so the next request can follow at once
  task automatic push_bit(input bit b, input bit fe, input bit typed);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.bit_in    <= b;
    in_if.frame_end <= fe;
    do @(posedge clk); while (!in_if.ready);
    if (!frame_violated || fe) useful_bits++;
    bits_sent++;
    destuff_bit(b, fe);
    if (typed) begin
      foreach (typed_results[k]) due_results.push_back(typed_results[k]);
    end else begin
      foreach (fresh_results[k]) due_results.push_back(fresh_results[k]);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_max_bits(input logic [15:0] v);
    drain_results();
    cfg_if.valid    <= 1'b1;
    cfg_if.max_bits <= v;
    do @(posedge clk); while (!cfg_if.ready);
    max_bits_cfg = v;
    cfg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // well-formed body with stuffing, optionally closed by a run of six ones and some junk
  function automatic void build_frame(int kept_len, bit with_violation, int one_pct);
    int  run;
    int  k;
    bit  b;
    frame_bits.delete();
    run = 0;
    for (k = 0; k < kept_len; k++) begin
      b = ($urandom_range(99) < one_pct);
      frame_bits.push_back(b);
      run = b ? run + 1 : 0;
      if (run == STUFF_RUN) begin
        frame_bits.push_back(1'b0);
        run = 0;
      end
    end
    if (with_violation) begin
      for (k = run; k <= STUFF_RUN; k++) frame_bits.push_back(1'b1);
      for (k = $urandom_range(0, 8); k > 0; k--) frame_bits.push_back(1'($urandom_range(1)));
    end
  endfunction

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bits.size(); i++)
      push_bit(frame_bits[i], i == frame_bits.size() - 1, 1'b0);
    frames_sent++;
  endtask

  task automatic run_random_frames(input int unsigned goal);
    int unsigned start;
    int unsigned pick;
    int          n;
    start = useful_bits;
    while (useful_bits - start < goal) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        if ($urandom_range(99) < 75) n = 8 * $urandom_range(1, 6);
        else n = $urandom_range(1, 47);
        build_frame(n, 1'b0, $urandom_range(30, 90));
      end else if (pick < 85) begin
        build_frame($urandom_range(0, 20), 1'b1, $urandom_range(30, 90));
      end else begin
        frame_bits.delete();
        for (n = $urandom_range(1, 40); n > 0; n--)
          frame_bits.push_back($urandom_range(99) < 80);
      end
      send_frame();
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.is_status   = out_if.is_status;
      got.data_byte   = out_if.data_byte;
      got.status_code = bdfc_pkg::status_t'(out_if.status_code);
      got.byte_total  = out_if.byte_total;
      got.last_result = out_if.last_result;
      results_checked++;
      if (got.is_status === 1'b1 && !$isunknown(got.status_code))
        status_mix[got.status_code]++;
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result", 1'b0, got, got);
      end else begin
        want = due_results.pop_front();
        if (got.is_status !== want.is_status || got.data_byte !== want.data_byte ||
            got.status_code !== want.status_code || got.byte_total !== want.byte_total ||
            got.last_result !== want.last_result)
          note_mismatch("result mismatch", 1'b1, want, got);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timed out with %0d results outstanding", due_results.size());
    $display("bit_destuff_frame_checker regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned w;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.bit_in    <= 1'b0;
    in_if.frame_end <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.max_bits <= '0;

    // kind  bit  end  max_bits  check  byte  status  total
    add_row(ROW_BIT, 1'b0, 1'b1, 16'd0, EXP_STATUS,  8'h00, bdfc_pkg::ST_NOT_BYTE,  13'd0);
    add_row(ROW_BIT, 1'b0, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b0, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b0, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_BYTE,    8'h1F, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b0, 1'b1, 16'd0, EXP_STATUS,  8'h00, bdfc_pkg::ST_OK,        13'd1);
    add_row(ROW_CFG, 1'b0, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b0, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b1, 16'd0, EXP_BOTH,    8'hFF, bdfc_pkg::ST_TOO_LONG,  13'd1);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b0, 16'd0, EXP_PREDICT, 8'h00, bdfc_pkg::ST_OK,        13'd0);
    add_row(ROW_BIT, 1'b1, 1'b1, 16'd0, EXP_STATUS,  8'h00, bdfc_pkg::ST_VIOLATION, 13'd0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_max_bits(dir_rows[i].cfg_val);
      end else begin
        typed_results.delete();
        if (dir_rows[i].exp_kind inside {EXP_BYTE, EXP_BOTH})
          typed_results.push_back(byte_result(dir_rows[i].data_byte, !dir_rows[i].frame_end));
        if (dir_rows[i].exp_kind inside {EXP_STATUS, EXP_BOTH})
          typed_results.push_back(status_result(dir_rows[i].status_code,
                                                dir_rows[i].byte_total));
        push_bit(dir_rows[i].bit_val, dir_rows[i].frame_end,
                 dir_rows[i].exp_kind != EXP_PREDICT);
        if (dir_rows[i].frame_end) frames_sent++;
      end
    end

    write_max_bits(16'($urandom_range(0, 48)));
    run_random_frames(115);
    write_max_bits(16'($urandom_range(100, 400)));
    run_random_frames(115);

    src_idle_pct = 49;
    snk_idle_pct = 38;
    write_max_bits(16'($urandom_range(8, 64)));
    run_random_frames(115);
    write_max_bits(bdfc_pkg::MAX_BITS_RESET);
    run_random_frames(115);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_max_bits(16'($urandom_range(0, 40)));
    run_random_frames(115);
    write_max_bits(16'hFFFF);
    run_random_frames(115);

    in_if.valid <= 1'b0;
    for (w = 0; w < END_WAIT_LIMIT && due_results.size() != 0; w++) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0d results never arrived", due_results.size());
      fail_count += due_results.size();
    end

    $display("sent %0d frames in %0d bit requests (%0d not ignored), %0d max_bits writes",
             frames_sent, bits_sent, useful_bits, cfg_writes);
    $display("checked %0d results, status ok/six-ones/not-byte/too-long %0d/%0d/%0d/%0d",
             results_checked, status_mix[0], status_mix[1], status_mix[2], status_mix[3]);
    if (fail_count == 0) begin
      $display("bit_destuff_frame_checker regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("bit_destuff_frame_checker regression: fail");
    end
    $finish;
  end

endmodule

// ----- bit_destuff_frame_checker.f -----
sv/bdfc_pkg.sv
sv/bdfc_in_if.sv
sv/bdfc_out_if.sv
sv/bdfc_cfg_if.sv
sv/bdfc_front.sv
sv/bdfc_queue.sv
sv/bdfc_back.sv
sv/bit_destuff_frame_checker.sv
test/bit_destuff_frame_checker_tb.sv
